@@ rtl/ile_pkg.sv @@
// Shared constants and types for the indexed list engine.
`timescale 1ns / 1ps

package ile_pkg;

    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int ACTION_W = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int CNT_W    = 5;

    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_INSERT     = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_REMOVE     = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_FIND       = 3'd6;

    // Per-cycle shift command broadcast to every cell.
    typedef struct packed {
        logic ins;   // open a hole at idx, shift the tail toward the back
        logic del;   // close the hole at idx, shift the tail toward the front
    } t_cell_ctl;

endpackage

@@ rtl/ile_cell.sv @@
// One list slot: holds an entry, shifts with its neighbors, matches a search key.
`timescale 1ns / 1ps

module ile_cell
    import ile_pkg::*;
#(
    parameter int INDEX       = 0,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int CNT_IW      = CNT_W
) (
    input  logic                   i_clk,
    input  t_cell_ctl              i_ctl,
    input  logic [CNT_IW-1:0]      i_idx,
    input  logic [CNT_IW-1:0]      i_used,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [VALUE_WIDTH-1:0] i_left,
    input  logic [VALUE_WIDTH-1:0] i_right,
    input  logic                   i_hit_before,
    output logic [VALUE_WIDTH-1:0] o_slot,
    output logic [VALUE_WIDTH-1:0] o_slot_next,
    output logic                   o_hit_before,
    output logic                   o_first
);

    localparam logic [CNT_IW-1:0] MY_IDX = CNT_IW'(INDEX);

    logic [VALUE_WIDTH-1:0] r_slot;
    logic [VALUE_WIDTH-1:0] n_slot;
    logic                   w_match;

    always_comb begin
        priority if (i_ctl.ins && (MY_IDX > i_idx)) begin
            n_slot = i_left;
        end else if (i_ctl.ins && (MY_IDX == i_idx)) begin
            n_slot = i_value;
        end else if (i_ctl.del && (MY_IDX >= i_idx)) begin
            n_slot = i_right;
        end else begin
            n_slot = r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    // only live entries take part in a search
    assign w_match      = (r_slot == i_value) && (MY_IDX < i_used);
    assign o_first      = w_match && !i_hit_before;
    assign o_hit_before = w_match || i_hit_before;
    assign o_slot       = r_slot;
    assign o_slot_next  = n_slot;

endmodule

@@ rtl/indexed_list_engine_core.sv @@
// Top level of the indexed list engine: a row of shifting slot cells plus control.
`timescale 1ns / 1ps

// Bounded ordered list of signed values held in a row of register cells.
// Input channel (i_in_valid / o_in_stall) carries one operation per item:
// push front/back, pop front/back, insert or remove at a position, or find.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// item: ok, found index, front and back values (-1 when empty), the entry
// count and empty/full flags, all as they stand after the operation.
// The result is registered at the edge that accepts the item. Throughput is
// one item per cycle while no result is stalled at the output; every cell
// shifts, loads or holds in the same cycle and all cells compare against the
// key at once, with the first-match flag rippling down the row.
// A full list refuses pushes and inserts, an empty list refuses pops, and a
// remove past the last entry is refused; refused items leave the list unchanged.
// Reset empties the list (entries are left as they are, only the count is
// cleared) and drops any pending result. While a result is stalled at the
// output, o_in_stall is raised and no new item is taken; the pending result
// holds until it is taken.
module indexed_list_engine_core
    import ile_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [ACTION_W-1:0]       i_action,
    input  logic signed [DATA_W-1:0]  i_value,
    input  logic [POS_W-1:0]          i_position,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_ok,
    output logic [CNT_W-1:0]          o_found_index,
    output logic signed [DATA_W-1:0]  o_front_value,
    output logic signed [DATA_W-1:0]  o_back_value,
    output logic [CNT_W-1:0]          o_entry_count,
    output logic                      o_is_empty,
    output logic                      o_is_full
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [CW-1:0]          r_used;
    logic [CW-1:0]          n_used;
    logic                   r_out_valid;
    logic                   r_ok;
    logic [CNT_W-1:0]       r_found;
    logic [DATA_W-1:0]      r_front;
    logic [DATA_W-1:0]      r_back;
    logic [CNT_W-1:0]       r_count;
    logic                   r_empty;
    logic                   r_full;

    logic                   w_accept;
    logic [VALUE_WIDTH-1:0] w_val;
    logic                   w_full;
    logic                   w_empty;
    logic [CW+7:0]          w_pos_ext;
    logic [CW+7:0]          w_used_ext;
    logic                   w_pos_lt;
    logic [CW+7:0]          w_ins_wide;
    t_cell_ctl              w_ctl;
    logic [CW-1:0]          w_idx;
    logic                   w_ok;
    logic                   w_is_find;
    logic [CW-1:0]          w_found;
    logic [CW+4:0]          w_found_ext;
    logic [CW+4:0]          w_count_ext;
    logic [CW-1:0]          w_back_pos;
    logic [VALUE_WIDTH-1:0] w_front_raw;
    logic [VALUE_WIDTH-1:0] w_back_raw;
    logic [DATA_W-1:0]      w_front;
    logic [DATA_W-1:0]      w_back;

    logic [VALUE_WIDTH-1:0] w_slot [CAPACITY];
    logic [VALUE_WIDTH-1:0] w_next [CAPACITY];
    logic [CAPACITY:0]      w_hit;
    logic [CAPACITY-1:0]    w_first;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // bring the 32-bit field to the stored width
    generate
        if (VALUE_WIDTH > DATA_W) begin : g_val_wide
            assign w_val = {{(VALUE_WIDTH-DATA_W){i_value[DATA_W-1]}}, i_value};
        end else begin : g_val_narrow
            assign w_val = i_value[VALUE_WIDTH-1:0];
        end
    endgenerate

    assign w_full     = (r_used == CAP_CNT);
    assign w_empty    = (r_used == '0);
    assign w_pos_ext  = {{CW{1'b0}}, i_position};
    assign w_used_ext = {8'b0, r_used};
    assign w_pos_lt   = (w_pos_ext < w_used_ext);
    assign w_ins_wide = w_pos_lt ? w_pos_ext : w_used_ext;

    always_comb begin
        w_ctl     = '0;
        w_idx     = '0;
        w_ok      = 1'b0;
        w_is_find = 1'b0;
        n_used    = r_used;
        unique case (i_action)
            ACT_PUSH_FRONT: begin
                if (!w_full) begin
                    w_ctl.ins = 1'b1;
                    w_ok      = 1'b1;
                    n_used    = r_used + 1'b1;
                end
            end
            ACT_PUSH_BACK: begin
                if (!w_full) begin
                    w_ctl.ins = 1'b1;
                    w_idx     = r_used;
                    w_ok      = 1'b1;
                    n_used    = r_used + 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (!w_empty) begin
                    w_ctl.del = 1'b1;
                    w_ok      = 1'b1;
                    n_used    = r_used - 1'b1;
                end
            end
            ACT_POP_BACK: begin
                if (!w_empty) begin
                    w_ok   = 1'b1;
                    n_used = r_used - 1'b1;
                end
            end
            ACT_INSERT: begin
                if (!w_full) begin
                    w_ctl.ins = 1'b1;
                    w_idx     = w_ins_wide[CW-1:0];
                    w_ok      = 1'b1;
                    n_used    = r_used + 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (w_pos_lt) begin
                    w_ctl.del = 1'b1;
                    w_idx     = w_pos_ext[CW-1:0];
                    w_ok      = 1'b1;
                    n_used    = r_used - 1'b1;
                end
            end
            ACT_FIND: begin
                w_ok      = 1'b1;
                w_is_find = 1'b1;
            end
            default: begin
            end
        endcase
        // cells only move on an accepted item
        if (!w_accept) begin
            w_ctl = '0;
        end
    end

    assign w_hit[0] = 1'b0;

    generate
        for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
            logic [VALUE_WIDTH-1:0] w_left;
            logic [VALUE_WIDTH-1:0] w_right;
            if (k == 0) begin : g_head
                assign w_left = w_slot[k];
            end else begin : g_mid_l
                assign w_left = w_slot[k-1];
            end
            if (k == CAPACITY - 1) begin : g_tail
                assign w_right = w_slot[k];
            end else begin : g_mid_r
                assign w_right = w_slot[k+1];
            end
            ile_cell #(
                .INDEX       (k),
                .VALUE_WIDTH (VALUE_WIDTH),
                .CNT_IW      (CW)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_idx        (w_idx),
                .i_used       (r_used),
                .i_value      (w_val),
                .i_left       (w_left),
                .i_right      (w_right),
                .i_hit_before (w_hit[k]),
                .o_slot       (w_slot[k]),
                .o_slot_next  (w_next[k]),
                .o_hit_before (w_hit[k+1]),
                .o_first      (w_first[k])
            );
        end
    endgenerate

    // first-match flag is one-hot or zero, so OR the positions together
    always_comb begin
        w_found = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_first[k]) begin
                w_found = w_found | CW'(k);
            end
        end
        if (!w_hit[CAPACITY]) begin
            w_found = r_used;
        end
        if (!w_is_find) begin
            w_found = '0;
        end
    end

    assign w_back_pos  = n_used - 1'b1;
    assign w_front_raw = w_next[0];
    assign w_back_raw  = w_next[w_back_pos[AW-1:0]];

    generate
        if (VALUE_WIDTH >= DATA_W) begin : g_out_wide
            assign w_front = w_front_raw[DATA_W-1:0];
            assign w_back  = w_back_raw[DATA_W-1:0];
        end else begin : g_out_narrow
            assign w_front = {{(DATA_W-VALUE_WIDTH){w_front_raw[VALUE_WIDTH-1]}}, w_front_raw};
            assign w_back  = {{(DATA_W-VALUE_WIDTH){w_back_raw[VALUE_WIDTH-1]}}, w_back_raw};
        end
    endgenerate

    assign w_found_ext = {5'b0, w_found};
    assign w_count_ext = {5'b0, n_used};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_used      <= n_used;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok    <= w_ok;
            r_found <= w_found_ext[CNT_W-1:0];
            r_front <= (n_used == '0) ? '1 : w_front;
            r_back  <= (n_used == '0) ? '1 : w_back;
            r_count <= w_count_ext[CNT_W-1:0];
            r_empty <= (n_used == '0);
            r_full  <= (n_used == CAP_CNT);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_found_index = r_found;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;
    assign o_entry_count = r_count;
    assign o_is_empty    = r_empty;
    assign o_is_full     = r_full;

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CAP_CNT)
        else $error("entry count above capacity");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted item produced no result");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ctl.ins) |=> (r_used == $past(r_used) + 1'b1))
        else $error("shift-in did not grow the list by one");

    a_one_first_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one first-match cell");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the indexed list engine core.
`timescale 1ns / 1ps

module tb_top;
    import ile_pkg::*;

    localparam int LIST_DEPTH  = DEF_CAPACITY;
    localparam int HOLD_CYCLES = 120;
    localparam int TAIL_CYCLES = 8;
    localparam longint TIMEOUT_NS = 64'd6_000_000;

    // No operation is decoded for this code; the block must refuse it.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

    typedef struct packed {
        logic                     ok;
        logic [CNT_W-1:0]         found;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] back;
        logic [CNT_W-1:0]         count;
        logic                     empty;
        logic                     full;
    } t_list_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [ACTION_W-1:0]      i_action;
    logic signed [DATA_W-1:0] i_value;
    logic [POS_W-1:0]         i_position;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic                     o_ok;
    logic [CNT_W-1:0]         o_found_index;
    logic signed [DATA_W-1:0] o_front_value;
    logic signed [DATA_W-1:0] o_back_value;
    logic [CNT_W-1:0]         o_entry_count;
    logic                     o_is_empty;
    logic                     o_is_full;

    logic signed [DATA_W-1:0] shadow_list[$];
    t_list_result             pending_results[$];
    int                       error_count = 0;
    bit                       send_idle_on = 1'b1;
    bit                       recv_idle_on = 1'b1;
    int                       hold_requests = 0;

    indexed_list_engine_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_ok          (o_ok),
        .o_found_index (o_found_index),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Applies one operation to the shadow list and returns the result it must produce.
    function automatic t_list_result apply_list_op(input logic [ACTION_W-1:0] act,
                                                   input logic signed [DATA_W-1:0] val,
                                                   input logic [POS_W-1:0] pos);
        t_list_result res;
        int           used;
        res  = '0;
        used = shadow_list.size();
        case (act)
            ACT_PUSH_FRONT: begin
                if (used < LIST_DEPTH) begin
                    shadow_list.insert(0, val);
                    res.ok = 1'b1;
                end
            end
            ACT_PUSH_BACK: begin
                if (used < LIST_DEPTH) begin
                    shadow_list = {shadow_list, val};
                    res.ok = 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (used > 0) begin
                    shadow_list.delete(0);
                    res.ok = 1'b1;
                end
            end
            ACT_POP_BACK: begin
                if (used > 0) begin
                    shadow_list.delete(used - 1);
                    res.ok = 1'b1;
                end
            end
            ACT_INSERT: begin
                if (used < LIST_DEPTH) begin
                    if (int'(pos) < used) shadow_list.insert(int'(pos), val);
                    else shadow_list = {shadow_list, val};
                    res.ok = 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (int'(pos) < used) begin
                    shadow_list.delete(int'(pos));
                    res.ok = 1'b1;
                end
            end
            ACT_FIND: begin
                res.found = CNT_W'(used);
                for (int i = 0; i < used; i++) begin
                    if (shadow_list[i] == val) begin
                        res.found = CNT_W'(i);
                        break;
                    end
                end
                res.ok = 1'b1;
            end
            default: ;
        endcase
        used = shadow_list.size();
        if (used > 0) begin
            res.front = shadow_list[0];
            res.back  = shadow_list[used-1];
        end else begin
            res.front = -1;
            res.back  = -1;
        end
        res.count = CNT_W'(used);
        res.empty = (used == 0);
        res.full  = (used >= LIST_DEPTH);
        return res;
    endfunction

    // Drives one item at the falling edge and holds it until the block takes it.
    task automatic send_op(input logic [ACTION_W-1:0] act,
                           input logic signed [DATA_W-1:0] val,
                           input logic [POS_W-1:0] pos);
        t_list_result res;
        @(negedge i_clk);
        while (send_idle_on && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_value    <= val;
        i_position <= pos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        res = apply_list_op(act, val, pos);
        pending_results = {pending_results, res};
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
                               input logic [DATA_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_list_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result item arrived with nothing pending");
                error_count++;
            end else begin
                exp_res = pending_results[0];
                pending_results.delete(0);
                check_field("ok", DATA_W'(exp_res.ok), DATA_W'(o_ok));
                check_field("found_index", DATA_W'(exp_res.found), DATA_W'(o_found_index));
                check_field("front_value", exp_res.front, o_front_value);
                check_field("back_value", exp_res.back, o_back_value);
                check_field("entry_count", DATA_W'(exp_res.count), DATA_W'(o_entry_count));
                check_field("is_empty", DATA_W'(exp_res.empty), DATA_W'(o_is_empty));
                check_field("is_full", DATA_W'(exp_res.full), DATA_W'(o_is_full));
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (recv_idle_on) begin
                i_out_stall <= ($urandom_range(99) < 27);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic test_empty_list_edges();
        send_op(ACT_POP_FRONT, 32'sd0, 8'd0);
        send_op(ACT_POP_BACK, -32'sd1, 8'd255);
        send_op(ACT_REMOVE, 32'sd0, 8'd0);
        send_op(ACT_FIND, 32'sd0, 8'd0);
        send_op(ACT_UNUSED, 32'sh7fffffff, 8'hff);
        // insert far past the end of an empty list lands at the front
        send_op(ACT_INSERT, 32'sh7fffffff, 8'd200);
    endtask

    task automatic test_capacity_limits();
        send_op(ACT_INSERT, 32'sh80000000, 8'd0);
        send_op(ACT_PUSH_BACK, -32'sd1, 8'd0);
        send_op(ACT_PUSH_FRONT, 32'sd0, 8'd0);
        send_op(ACT_INSERT, 32'sh5a5a5a5a, 8'd2);
        send_op(ACT_INSERT, 32'sha5a5a5a5, 8'd4);   // index equal to count appends
        for (int k = 0; shadow_list.size() < LIST_DEPTH; k++) begin
            send_op((k % 2) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                    (k == 3) ? -32'sd1 : $urandom, 8'd0);
        end
        send_op(ACT_PUSH_BACK, 32'sd1, 8'd0);
        send_op(ACT_PUSH_FRONT, 32'sd2, 8'd0);
        send_op(ACT_INSERT, 32'sd3, 8'd3);
        send_op(ACT_FIND, -32'sd1, 8'd0);           // duplicate: first match wins
        send_op(ACT_FIND, 32'sh12345678, 8'd0);
        send_op(ACT_REMOVE, 32'sd0, 8'd16);
        send_op(ACT_REMOVE, 32'sd0, 8'd15);
        send_op(ACT_POP_FRONT, 32'sd0, 8'd0);
        send_op(ACT_POP_BACK, 32'sd0, 8'd0);
    endtask

    // Alternates growing and shrinking runs so the list swings between empty and full.
    task automatic test_random_ops(input int n_items);
        logic signed [DATA_W-1:0] value_pool[8];
        logic [ACTION_W-1:0]      act;
        logic signed [DATA_W-1:0] val;
        logic [POS_W-1:0]         pos;
        bit                       growing;
        int                       run_left;
        int                       r;
        int                       used;
        value_pool = '{32'sd0, -32'sd1, 32'sh7fffffff, 32'sh80000000,
                       32'sd1, 32'sh55555555, 32'shaaaaaaaa, 32'sh0000ffff};
        growing  = 1'($urandom_range(1));
        run_left = 0;
        for (int n = 0; n < n_items; n++) begin
            if (run_left == 0) begin
                growing  = ~growing;
                run_left = $urandom_range(60, 20);
            end
            run_left--;
            used = shadow_list.size();
            r    = $urandom_range(99);
            if (growing) begin
                if (r < 30)      act = ACT_PUSH_BACK;
                else if (r < 50) act = ACT_PUSH_FRONT;
                else if (r < 75) act = ACT_INSERT;
                else if (r < 82) act = ACT_FIND;
                else if (r < 88) act = ACT_POP_FRONT;
                else if (r < 93) act = ACT_POP_BACK;
                else if (r < 98) act = ACT_REMOVE;
                else             act = ACT_UNUSED;
            end else begin
                if (r < 8)       act = ACT_PUSH_BACK;
                else if (r < 14) act = ACT_PUSH_FRONT;
                else if (r < 22) act = ACT_INSERT;
                else if (r < 32) act = ACT_FIND;
                else if (r < 55) act = ACT_POP_FRONT;
                else if (r < 75) act = ACT_POP_BACK;
                else if (r < 98) act = ACT_REMOVE;
                else             act = ACT_UNUSED;
            end
            if ($urandom_range(9) == 0) pos = POS_W'($urandom_range(255));
            else pos = POS_W'($urandom_range(used + 1));
            if (act == ACT_FIND && used > 0 && $urandom_range(9) < 6)
                val = shadow_list[$urandom_range(used - 1)];
            else if ($urandom_range(1))
                val = value_pool[3'($urandom_range(7))];
            else
                val = $urandom;
            send_op(act, val, pos);
        end
    endtask

    task automatic test_output_hold();
        send_idle_on = 1'b0;
        hold_requests++;
        test_random_ops(40);
        send_idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        test_random_ops(20);
        wait_all_results();
        test_random_ops(20);
    endtask

    task automatic test_no_idle_stretch();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        test_random_ops(300);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_action   = ACT_PUSH_FRONT;
        i_value    = '0;
        i_position = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list_edges();
        test_capacity_limits();
        test_random_ops(400);
        test_no_idle_stretch();
        test_output_hold();
        test_sender_pause();
        test_random_ops(870);

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
